// ===== hw/rtl/ordered_list_move_to_front_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list move-to-front core
// Shared macros for concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_MOVE_TO_FRONT_CORE_DEFINES_SVH
`define ORDERED_LIST_MOVE_TO_FRONT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OLMTF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olmtf check failed");

// next-cycle implication, checked outside reset
`define OLMTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olmtf check failed");

`endif

// ===== hw/rtl/olmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// olmtf_pkg
// Types and constants shared by the move-to-front list cells and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olmtf_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 32;
   localparam int POS_W   = 8;
   localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int OCNT_W  = 7;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_INSERT_AT  = 3'd4,
      CMD_REMOVE_AT  = 3'd5,
      CMD_FIND_MTF   = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_FULL      = 3'd3,
      STS_BAD_POS   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHR,
      CELL_SHL
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          lo;
      logic [IDX_W-1:0]          hi;
      logic [IDX_W-1:0]          sel;
      logic signed [VAL_W-1:0]   value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/olmtf_cell.sv =====
// ----------------------------------------------------------------------------
// olmtf_cell
// One list slot: holds an entry, shifts from either neighbor, compares and
// drives its entry onto the read bus when selected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olmtf_cell
   import olmtf_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [IDX_W-1:0]        cell_idx,
   input  wire cell_ctl_type            ctl,
   input  wire logic signed [VAL_W-1:0] left_data,
   input  wire logic signed [VAL_W-1:0] right_data,
   output logic signed [VAL_W-1:0]      entry,
   output logic                         hit,
   output logic signed [VAL_W-1:0]      rd_data
);

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic                    selected;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_SHR: begin
            // open a slot at lo, slide lo..hi-1 one place toward the tail
            if (cell_idx == ctl.lo) begin
               entry_in = ctl.value;
            end else if (cell_idx > ctl.lo && cell_idx <= ctl.hi) begin
               entry_in = left_data;
            end
         end
         CELL_SHL: begin
            // close the slot at lo, pull lo+1..hi one place toward the head
            if (cell_idx >= ctl.lo && cell_idx < ctl.hi) begin
               entry_in = right_data;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign selected = (cell_idx == ctl.sel);
   assign entry    = entry_ff;
   assign hit      = selected && (entry_ff == ctl.value);
   assign rd_data  = selected ? entry_ff : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/olmtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// olmtf_ctrl
// Command sequencer: decodes a beat, drives the cell chain, walks the
// search one cell a cycle and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olmtf_ctrl
   import olmtf_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [2:0]              req_tuser,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic [POS_W-1:0]        req_position,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic signed [VAL_W-1:0]      rsp_result_value,
   output logic [2:0]                   rsp_status,
   output logic [OCNT_W-1:0]            rsp_entry_count,
   output logic                         rsp_is_empty,
   output cell_ctl_type                 ctl,
   input  wire logic                    chain_hit,
   input  wire logic signed [VAL_W-1:0] chain_rd
);

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic signed [VAL_W-1:0] res_ff, res_in;
   status_type              sts_ff, sts_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_res_ff, rsp_res_in;
   status_type              rsp_sts_ff, rsp_sts_in;
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic [IDX_W-1:0]        ins_idx;
   logic [IDX_W-1:0]        rm_idx;
   logic                    is_full;
   logic                    is_zero;
   logic                    scan_last;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_zero   = (count_ff == '0);
   assign scan_last = (CNT_W'(scan_ff) == count_ff - CNT_W'(1));

   // slot to open for a push or insert, clamped to the tail
   always_comb begin
      case (cmd_ff)
         CMD_PUSH_FRONT: ins_idx = '0;
         CMD_PUSH_BACK:  ins_idx = IDX_W'(count_ff);
         default: begin
            if (CMP_W'(pos_ff) > CMP_W'(count_ff)) begin
               ins_idx = IDX_W'(count_ff);
            end else begin
               ins_idx = IDX_W'(pos_ff);
            end
         end
      endcase
   end

   // slot to close for a pop or remove
   always_comb begin
      case (cmd_ff)
         CMD_POP_FRONT: rm_idx = '0;
         CMD_POP_BACK:  rm_idx = IDX_W'(count_ff - CNT_W'(1));
         default:       rm_idx = IDX_W'(pos_ff);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      res_in       = res_ff;
      sts_in       = sts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      req_tready   = (state_ff == ST_IDLE);
      ctl.op       = CELL_HOLD;
      ctl.lo       = '0;
      ctl.hi       = '0;
      ctl.sel      = '0;
      ctl.value    = val_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               val_in   = req_value;
               pos_in   = req_position;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_in   = '0;
            sts_in   = STS_OK;
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
                  if (is_full) begin
                     sts_in = STS_FULL;
                  end else begin
                     ctl.op   = CELL_SHR;
                     ctl.lo   = ins_idx;
                     ctl.hi   = IDX_W'(DEPTH - 1);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
                  if (is_zero) begin
                     sts_in = STS_EMPTY;
                  end else if (cmd_ff == CMD_REMOVE_AT &&
                               CMP_W'(pos_ff) >= CMP_W'(count_ff)) begin
                     sts_in = STS_BAD_POS;
                  end else begin
                     ctl.sel  = rm_idx;
                     res_in   = chain_rd;
                     ctl.op   = CELL_SHL;
                     ctl.lo   = rm_idx;
                     ctl.hi   = IDX_W'(count_ff - CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               CMD_FIND_MTF: begin
                  if (is_zero) begin
                     sts_in = STS_NOT_FOUND;
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  sts_in = STS_OK;
               end
            endcase
         end
         ST_SCAN: begin
            ctl.sel = scan_ff;
            if (chain_hit) begin
               // rotate head..hit one place down and put the value at the head
               ctl.op   = CELL_SHR;
               ctl.lo   = '0;
               ctl.hi   = scan_ff;
               res_in   = val_ff;
               state_in = ST_DONE;
            end else if (scan_last) begin
               sts_in   = STS_NOT_FOUND;
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_sts_in   = sts_ff;
               rsp_cnt_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      scan_ff    <= scan_in;
      res_ff     <= res_in;
      sts_ff     <= sts_in;
      rsp_res_ff <= rsp_res_in;
      rsp_sts_ff <= rsp_sts_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_status       = rsp_sts_ff;
   assign rsp_entry_count  = OCNT_W'(rsp_cnt_ff);
   assign rsp_is_empty     = (rsp_cnt_ff == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_move_to_front_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_move_to_front_core
// Bounded move-to-front list of signed 32-bit values on a chain of cells.
// ----------------------------------------------------------------------------
// The list holds up to 64 entries, head first, one entry per cell; each cell
// shifts from its neighbor so push, pop, insert and remove finish in a single
// chain update. One command is in flight at a time: push, pop, insert and
// remove pass through the decode and done states before the response beat,
// as does a search of an empty list; otherwise a search walks the list one
// cell per cycle from the head until it hits or passes the last entry. The
// next request beat is taken once the response sits in the output register,
// even while it waits to be taken. Entries hold no reset value; only the
// first count entries are ever read. Status reports empty, not found, full
// and bad position, so a data value of -1 is never ambiguous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_move_to_front_core_defines.svh"

module ordered_list_move_to_front_core
   import olmtf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value[31:0], position[39:32]
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // result_value[31:0], entry_count[38:32],
                                         // is_empty[39]
   output logic [2:0]       rsp_tuser    // status[2:0]
);

   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] cell_entry [DEPTH];
   logic signed [VAL_W-1:0] cell_left  [DEPTH];
   logic signed [VAL_W-1:0] cell_right [DEPTH];
   logic signed [VAL_W-1:0] cell_rd    [DEPTH];
   logic [DEPTH-1:0]        cell_hit;
   logic signed [VAL_W-1:0] chain_rd;
   logic                    chain_hit;
   logic signed [VAL_W-1:0] rsp_result_value;
   logic [2:0]              rsp_status;
   logic [OCNT_W-1:0]       rsp_entry_count;
   logic                    rsp_is_empty;

   olmtf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_value        (req_tdata[31:0]),
      .req_position     (req_tdata[39:32]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .ctl              (ctl),
      .chain_hit        (chain_hit),
      .chain_rd         (chain_rd)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_left[i] = '0;
      end else begin : g_mid
         assign cell_left[i] = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign cell_right[i] = '0;
      end else begin : g_body
         assign cell_right[i] = cell_entry[i+1];
      end

      olmtf_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .ctl        (ctl),
         .left_data  (cell_left[i]),
         .right_data (cell_right[i]),
         .entry      (cell_entry[i]),
         .hit        (cell_hit[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // only the selected cell drives a nonzero read value
   always_comb begin
      chain_rd = '0;
      for (int i = 0; i < DEPTH; i++) begin
         chain_rd = chain_rd | cell_rd[i];
      end
   end

   assign chain_hit = |cell_hit;

   assign rsp_tdata = {rsp_is_empty, rsp_entry_count, rsp_result_value};
   assign rsp_tuser = rsp_status;

   `OLMTF_ASSERT_IMP(a_hit_single, clock, reset, 1'b1, $onehot0(cell_hit))
   `OLMTF_ASSERT_IMP(a_empty_flag, clock, reset, rsp_tvalid,
                     rsp_tdata[39] == (rsp_tdata[38:32] == '0))
   `OLMTF_ASSERT_IMP(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == STS_FULL,
                     rsp_tdata[38:32] == OCNT_W'(DEPTH))
   `OLMTF_ASSERT_NEXT(a_one_cmd, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the move-to-front list core. A scoreboard keeps
// its own copy of the list, predicts each response beat from the accepted
// command beats, and compares every field of each response in order.
// Stimulus is a short directed pass over the corner cases, then phases of
// random commands that grow, drain, fill or churn the list, with random
// gaps on both sides and one long response back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import olmtf_pkg::*;
;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         ITEM_TARGET = 1450;
   localparam int         HOLD_CYCLES = 500;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, RUN_FILL, RUN_DRAIN} mix_type;

   class mtf_list_scoreboard;
      typedef struct {
         logic [31:0] result_value;
         status_type  status;
         logic [6:0]  entry_count;
         logic        is_empty;
      } rsp_fields_type;

      logic [31:0]     slots [DEPTH];
      int unsigned     fill;
      rsp_fields_type  expected_q [$];
      int unsigned     mismatches;
      int unsigned     beats_checked;
      int unsigned     search_hits;
      int unsigned     peak_fill;
      int unsigned     status_seen [5];

      function void insert_entry(int unsigned idx, logic [31:0] v);
         int unsigned i;
         for (i = fill; i > idx; i--)
            slots[i] = slots[i - 1];
         slots[idx] = v;
         fill++;
         if (fill > peak_fill)
            peak_fill = fill;
      endfunction

      function logic [31:0] take_entry(int unsigned idx);
         logic [31:0] v;
         int unsigned i;
         v = slots[idx];
         for (i = idx; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
         fill--;
         return v;
      endfunction

      // predict the response of one accepted command beat
      function void note_request(logic [2:0] cmd, logic [31:0] value, logic [7:0] pos);
         rsp_fields_type e;
         int unsigned idx;
         e.result_value = '0;
         e.status       = STS_OK;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
               if (fill >= DEPTH)
                  e.status = STS_FULL;
               else if (cmd == CMD_PUSH_FRONT)
                  insert_entry(0, value);
               else if (cmd == CMD_PUSH_BACK)
                  insert_entry(fill, value);
               else
                  insert_entry((pos > fill) ? fill : pos, value);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (fill == 0)
                  e.status = STS_EMPTY;
               else
                  e.result_value = take_entry((cmd == CMD_POP_FRONT) ? 0 : fill - 1);
            end
            CMD_REMOVE_AT: begin
               if (fill == 0)
                  e.status = STS_EMPTY;
               else if (pos >= fill)
                  e.status = STS_BAD_POS;
               else
                  e.result_value = take_entry(pos);
            end
            CMD_FIND_MTF: begin
               for (idx = 0; idx < fill; idx++)
                  if (slots[idx] == value)
                     break;
               if (idx >= fill) begin
                  e.status = STS_NOT_FOUND;
               end else begin
                  e.result_value = take_entry(idx);
                  insert_entry(0, e.result_value);
                  search_hits++;
               end
            end
            default: ;
         endcase
         e.entry_count = fill[6:0];
         e.is_empty    = (fill == 0);
         status_seen[int'(e.status)]++;
         expected_q.push_back(e);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH beat %0d %s: got 0x%08h, expected 0x%08h",
                  beats_checked, field, got, want);
         mismatches++;
      endtask

      task check_response(logic [39:0] data, logic [2:0] user);
         rsp_fields_type e;
         if (expected_q.size() == 0) begin
            report("beat with nothing outstanding", data[31:0], '0);
            return;
         end
         e = expected_q.pop_front();
         beats_checked++;
         if (data[31:0] !== e.result_value)
            report("result_value", data[31:0], e.result_value);
         if (data[38:32] !== e.entry_count)
            report("entry_count", 32'(data[38:32]), 32'(e.entry_count));
         if (data[39] !== e.is_empty)
            report("is_empty", 32'(data[39]), 32'(e.is_empty));
         if (user !== e.status)
            report("status", 32'(user), 32'(e.status));
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // value[31:0], position[39:32]
   logic [2:0]  req_tuser;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // result_value[31:0], entry_count[38:32], is_empty[39]
   logic [2:0]  rsp_tuser;   // status[2:0]

   mtf_list_scoreboard sb;
   logic [31:0]        value_pool [16];
   int unsigned        sent_count;
   bit                 quiet;
   bit                 hold_rsp;

   ordered_list_move_to_front_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return value_pool[$urandom_range(0, 15)];
      if (r < 45)
         return 32'($urandom_range(0, 3));   // force duplicates
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_pos(int unsigned fill);
      if ($urandom_range(0, 99) < 70)
         return 8'($urandom_range(0, fill));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] pick_cmd(mix_type mix, int unsigned fill);
      int unsigned push_pct;
      int unsigned pop_pct;
      int unsigned r;
      case (mix)
         MIX_GROW:     begin push_pct = 55; pop_pct = 20; end
         MIX_SHRINK:   begin push_pct = 20; pop_pct = 55; end
         MIX_BALANCED: begin push_pct = 35; pop_pct = 35; end
         RUN_FILL: begin
            push_pct = (fill < DEPTH) ? 95 : 35;
            pop_pct  = (fill < DEPTH) ? 0 : 25;
         end
         default:      begin push_pct = (fill > 0) ? 0 : 30; pop_pct = (fill > 0) ? 92 : 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
         case ($urandom_range(0, 2))
            0: return CMD_PUSH_FRONT;
            1: return CMD_PUSH_BACK;
            default: return CMD_INSERT_AT;
         endcase
      end
      if (r < push_pct + pop_pct) begin
         case ($urandom_range(0, 2))
            0: return CMD_POP_FRONT;
            1: return CMD_POP_BACK;
            default: return CMD_REMOVE_AT;
         endcase
      end
      if (r < 97)
         return CMD_FIND_MTF;
      return CMD_UNUSED;
   endfunction

   // entered and left at a falling edge; valid stays high across back-to-back beats
   task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] value,
                           input logic [7:0] pos);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {pos, value};
      req_tuser  = cmd;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(cmd, value, pos);
      sent_count++;
      if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK || cmd == CMD_INSERT_AT)
         value_pool[$urandom_range(0, 15)] = value;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // response side: random stalls, forced low during the hold-off
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         rsp_tready = !(hold_rsp || stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   // long back-pressure: the core fills its output and stalls its input
   initial begin
      hold_rsp = 1'b0;
      wait (sent_count >= 400);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      mix_type     mix;
      logic [2:0]  cmd;
      logic [31:0] value;
      int unsigned phase_len;
      bit          first_phase;

      sb         = new();
      sent_count = 0;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      value_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h1, 32'h2, 32'h3, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                     32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h2, 32'h3};
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty list, extremes, clamp, bad positions, search cases
      send_cmd(CMD_FIND_MTF,   32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_POP_FRONT,  32'h0,         8'd0);
      send_cmd(CMD_POP_BACK,   32'h0,         8'd0);
      send_cmd(CMD_REMOVE_AT,  32'h0,         8'd0);
      send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 8'd0);
      send_cmd(CMD_PUSH_BACK,  32'h8000_0000, 8'd255);
      send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_INSERT_AT,  32'h0,         8'd255);
      send_cmd(CMD_INSERT_AT,  32'h5A5A_5A5A, 8'd1);
      send_cmd(CMD_FIND_MTF,   32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_FIND_MTF,   32'h0,         8'd0);
      send_cmd(CMD_FIND_MTF,   32'h1234_5678, 8'd0);
      send_cmd(CMD_REMOVE_AT,  32'h0,         8'd255);
      send_cmd(CMD_REMOVE_AT,  32'h0,         8'd5);
      send_cmd(CMD_REMOVE_AT,  32'h0,         8'd2);
      send_cmd(CMD_UNUSED,     $urandom,      8'($urandom));
      send_cmd(CMD_POP_FRONT,  32'h0,         8'd0);
      send_cmd(CMD_POP_BACK,   32'h0,         8'd0);
      send_cmd(CMD_INSERT_AT,  32'hA5A5_A5A5, 8'd0);
      send_cmd(CMD_FIND_MTF,   32'h8000_0000, 8'd0);
      send_cmd(CMD_POP_FRONT,  32'h0,         8'd0);
      send_cmd(CMD_POP_BACK,   32'h0,         8'd0);
      send_cmd(CMD_REMOVE_AT,  32'h0,         8'd0);
      send_cmd(CMD_FIND_MTF,   32'h0,         8'd0);

      // random phases; the first one fills the list and hammers it while full
      first_phase = 1'b1;
      while (sent_count < ITEM_TARGET) begin
         mix = first_phase ? RUN_FILL : mix_type'($urandom_range(0, 4));
         first_phase = 1'b0;
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = (mix == RUN_FILL || mix == RUN_DRAIN) ? 90 : $urandom_range(30, 120);
         repeat (phase_len) begin
            cmd = pick_cmd(mix, sb.fill);
            if (cmd == CMD_FIND_MTF && $urandom_range(0, 99) < 70)
               value = value_pool[$urandom_range(0, 15)];
            else
               value = pick_value();
            send_cmd(cmd, value, pick_pos(sb.fill));
         end
      end
      req_tvalid = 1'b0;
      quiet = 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Run covered %0d commands, %0d responses checked, peak depth %0d of %0d,",
               sent_count, sb.beats_checked, sb.peak_fill, DEPTH);
      $display("%0d search hits. Status mix: ok %0d, empty %0d, not found %0d, full %0d, bad position %0d.",
               sb.search_hits, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4]);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
